// ===== design/plst_pkg.sv =====
package plst_pkg;

    localparam int DEPTH_DEF      = 16;
    localparam int DATA_WIDTH_DEF = 32;

    // operation codes on func
    localparam logic [2:0] FN_INS_FRONT = 3'd0;
    localparam logic [2:0] FN_INS_BACK  = 3'd1;
    localparam logic [2:0] FN_INS_POS   = 3'd2;
    localparam logic [2:0] FN_DEL_FRONT = 3'd3;
    localparam logic [2:0] FN_DEL_BACK  = 3'd4;
    localparam logic [2:0] FN_DEL_POS   = 3'd5;
    localparam logic [2:0] FN_SEARCH    = 3'd6;
    localparam logic [2:0] FN_DUMP      = 3'd7;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_BADPOS   = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_SCAN_RD,
        S_SCAN_CHK,
        S_FINISH
    } t_state;

endpackage

// ===== design/plst_mem.sv =====
module plst_mem #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    localparam int IDX_W     = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic [IDX_W-1:0]      i_addr,
    input  logic                  i_rd_en,
    input  logic                  i_wr_en,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== design/positional_list_store_top.sv =====
// channel  direction  handshake                 payload
// in       sink       i_in_valid / o_in_stall   i_func, i_value, i_position
// out      source     o_out_valid / i_out_stall o_status, o_item_value, o_item_position,
//                                               o_element_count, o_last
//
// Single-port ring memory; one ring address unit and the memory port serve every step.
// Delete front/back and rejects go straight to finish; insert front/back writes the item once;
// insert and delete at position move each element with a read and a write, insert then writes
// the item; search and dump read and check each element visited (a search miss ends in finish).
// Synchronous active-low reset empties the list; memory contents are not cleared.
// The input stalls until an item is done; a stalled output holds the sequencer.
module positional_list_store_top
    import plst_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [2:0]         i_func,
    input  logic signed [31:0] i_value,
    input  logic [7:0]         i_position,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic signed [31:0] o_item_value,
    output logic [6:0]         o_item_position,
    output logic [6:0]         o_element_count,
    output logic               o_last
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_state                r_state, n_state;
    logic [2:0]            r_func, n_func;
    logic [DATA_WIDTH-1:0] r_value, n_value;
    logic [IDX_W-1:0]      r_front, n_front;
    logic [CNT_W-1:0]      r_count, n_count;
    logic [CNT_W-1:0]      r_k, n_k;
    logic [CNT_W-1:0]      r_pos, n_pos;
    logic [2:0]            r_status, n_status;

    logic                  r_o_valid, n_o_valid;
    logic [2:0]            r_o_status, n_o_status;
    logic [31:0]           r_o_value, n_o_value;
    logic [6:0]            r_o_pos, n_o_pos;
    logic [6:0]            r_o_count, n_o_count;
    logic                  r_o_last, n_o_last;

    logic                  accept;
    logic                  out_free;
    logic [CNT_W-1:0]      k_op;
    logic [CNT_W:0]        addr_sum;
    logic [IDX_W-1:0]      mem_addr;
    logic                  mem_rd;
    logic                  mem_wr;
    logic [DATA_WIDTH-1:0] mem_wdata;
    logic [DATA_WIDTH-1:0] mem_rdata;
    logic [DATA_WIDTH+31:0] in_wide;
    logic [DATA_WIDTH+31:0] out_wide;
    logic [CNT_W-1:0]      pos_m1;
    logic                  is_full;
    logic                  is_empty;
    logic                  ins_bad;
    logic                  del_bad;
    logic                  at_last;

    assign in_wide  = {{DATA_WIDTH{1'b0}}, i_value};
    assign out_wide = {32'd0, mem_rdata};

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_o_valid || !i_out_stall;

    assign is_full  = (r_count == CNT_W'(DEPTH));
    assign is_empty = (r_count == '0);
    assign ins_bad  = (i_position == 8'd0) ||
                      ({1'b0, i_position} > (9'(r_count) + 9'd1));
    assign del_bad  = (i_position == 8'd0) || ({1'b0, i_position} > 9'(r_count));
    assign pos_m1   = CNT_W'(i_position - 8'd1);
    assign at_last  = ((r_k + CNT_W'(1)) == r_count);

    // ring address: (front + k) mod DEPTH, sum stays below 2*DEPTH
    always_comb begin
        addr_sum = (CNT_W + 1)'(r_front) + {1'b0, k_op};
        if (addr_sum >= (CNT_W + 1)'(DEPTH)) begin
            addr_sum = addr_sum - (CNT_W + 1)'(DEPTH);
        end
    end
    assign mem_addr = addr_sum[IDX_W-1:0];

    plst_mem #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_mem (
        .i_clk     (i_clk),
        .i_addr    (mem_addr),
        .i_rd_en   (mem_rd),
        .i_wr_en   (mem_wr),
        .i_wr_data (mem_wdata),
        .o_rd_data (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_value    <= n_value;
        r_k        <= n_k;
        r_pos      <= n_pos;
        r_status   <= n_status;
        r_o_status <= n_o_status;
        r_o_value  <= n_o_value;
        r_o_pos    <= n_o_pos;
        r_o_count  <= n_o_count;
        r_o_last   <= n_o_last;
    end

    always_comb begin
        n_state    = r_state;
        n_func     = r_func;
        n_value    = r_value;
        n_front    = r_front;
        n_count    = r_count;
        n_k        = r_k;
        n_pos      = r_pos;
        n_status   = r_status;
        n_o_valid  = r_o_valid && i_out_stall;
        n_o_status = r_o_status;
        n_o_value  = r_o_value;
        n_o_pos    = r_o_pos;
        n_o_count  = r_o_count;
        n_o_last   = r_o_last;
        k_op       = r_k;
        mem_rd     = 1'b0;
        mem_wr     = 1'b0;
        mem_wdata  = mem_rdata;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_func   = i_func;
                    n_value  = in_wide[DATA_WIDTH-1:0];
                    n_status = ST_OK;
                    n_state  = S_FINISH;
                    case (i_func)
                        FN_INS_FRONT: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_front = (r_front == '0) ? IDX_W'(DEPTH - 1)
                                                          : r_front - IDX_W'(1);
                                n_k     = '0;
                                n_state = S_INS_WR;
                            end
                        end
                        FN_INS_BACK: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_k     = r_count;
                                n_state = S_INS_WR;
                            end
                        end
                        FN_INS_POS: begin
                            if (is_full) begin
                                n_status = ST_FULL;
                            end else if (ins_bad) begin
                                n_status = ST_BADPOS;
                            end else begin
                                n_k     = r_count;
                                n_pos   = pos_m1;
                                n_state = (r_count > pos_m1) ? S_SHIFT_RD : S_INS_WR;
                            end
                        end
                        FN_DEL_FRONT: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_front = (r_front == IDX_W'(DEPTH - 1)) ? '0
                                                                 : r_front + IDX_W'(1);
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        FN_DEL_BACK: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        FN_DEL_POS: begin
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else if (del_bad) begin
                                n_status = ST_BADPOS;
                            end else if (({1'b0, pos_m1} + (CNT_W + 1)'(1)) <
                                         {1'b0, r_count}) begin
                                n_k     = pos_m1;
                                n_state = S_SHIFT_RD;
                            end else begin
                                n_count = r_count - CNT_W'(1);
                            end
                        end
                        default: begin
                            // search and dump walk from the front
                            if (is_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_k     = '0;
                                n_state = S_SCAN_RD;
                            end
                        end
                    endcase
                end
            end

            S_SHIFT_RD: begin
                mem_rd  = 1'b1;
                k_op    = (r_func == FN_INS_POS) ? r_k - CNT_W'(1) : r_k + CNT_W'(1);
                n_state = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                mem_wr = 1'b1;
                if (r_func == FN_INS_POS) begin
                    n_k     = r_k - CNT_W'(1);
                    n_state = ((r_k - CNT_W'(1)) > r_pos) ? S_SHIFT_RD : S_INS_WR;
                end else begin
                    n_k = r_k + CNT_W'(1);
                    if (({1'b0, r_k} + (CNT_W + 1)'(2)) < {1'b0, r_count}) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_count = r_count - CNT_W'(1);
                        n_state = S_FINISH;
                    end
                end
            end

            S_INS_WR: begin
                mem_wr    = 1'b1;
                mem_wdata = r_value;
                n_count   = r_count + CNT_W'(1);
                n_state   = S_FINISH;
            end

            S_SCAN_RD: begin
                mem_rd  = 1'b1;
                n_state = S_SCAN_CHK;
            end

            S_SCAN_CHK: begin
                if (r_func == FN_SEARCH) begin
                    if (mem_rdata == r_value) begin
                        if (out_free) begin
                            n_o_valid  = 1'b1;
                            n_o_status = ST_OK;
                            n_o_value  = out_wide[31:0];
                            n_o_pos    = 7'(r_k) + 7'd1;
                            n_o_count  = 7'(r_count);
                            n_o_last   = 1'b1;
                            n_state    = S_IDLE;
                        end
                    end else if (at_last) begin
                        n_status = ST_NOTFOUND;
                        n_state  = S_FINISH;
                    end else begin
                        n_k     = r_k + CNT_W'(1);
                        n_state = S_SCAN_RD;
                    end
                end else if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = ST_OK;
                    n_o_value  = out_wide[31:0];
                    n_o_pos    = 7'(r_k) + 7'd1;
                    n_o_count  = 7'(r_count);
                    n_o_last   = at_last;
                    n_k        = r_k + CNT_W'(1);
                    n_state    = at_last ? S_IDLE : S_SCAN_RD;
                end
            end

            S_FINISH: begin
                if (out_free) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_status;
                    n_o_value  = '0;
                    n_o_pos    = '0;
                    n_o_count  = 7'(r_count);
                    n_o_last   = 1'b1;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid     = r_o_valid;
    assign o_status        = r_o_status;
    assign o_item_value    = r_o_value;
    assign o_item_position = r_o_pos;
    assign o_element_count = r_o_count;
    assign o_last          = r_o_last;

endmodule

// ===== tb/sv/tb.sv =====
module tb
    import plst_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIST_DEPTH   = DEPTH_DEF;
    localparam int RANDOM_ITEMS = 186;
    localparam int EPISODE_LEN  = 22;
    localparam int HOLD_CYCLES  = 300;
    localparam int IDLE_LIMIT   = 3000;
    localparam int TAIL_CYCLES  = 60;

    typedef struct {
        logic [2:0]  func;
        logic [31:0] value;
        logic [7:0]  position;
        bit          drain;
    } list_op_t;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] item_value;
        logic [6:0]  item_position;
        logic [6:0]  element_count;
        logic        last;
    } list_result_t;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_stall;
    logic [2:0]         i_func = FN_INS_FRONT;
    logic signed [31:0] i_value = '0;
    logic [7:0]         i_position = '0;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic [2:0]         o_status;
    logic signed [31:0] o_item_value;
    logic [6:0]         o_item_position;
    logic [6:0]         o_element_count;
    logic               o_last;

    list_op_t     pending_ops[$];
    list_result_t expected_results[$];
    logic [31:0]  list_image[$];

    int  ops_accepted = 0;
    int  ops_offered = 0;
    int  results_seen = 0;
    int  n_mismatch = 0;
    int  idle_cycles = 0;
    int  hold_left = 0;
    bit  hold_done = 1'b0;
    logic quiet;

    logic [31:0] value_pool [0:7] = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0,
                                      32'h1, 32'h5a5a_5a5a, 32'ha5a5_a5a5, 32'h0000_1234};

    // no random idling on either side while this window is open
    assign quiet = (ops_accepted >= 120) && (ops_accepted < 160);

    positional_list_store_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_func          (i_func),
        .i_value         (i_value),
        .i_position      (i_position),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_item_value    (o_item_value),
        .o_item_position (o_item_position),
        .o_element_count (o_element_count),
        .o_last          (o_last)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $time, what);
        n_mismatch++;
    endtask

    task automatic push_result(input logic [2:0] st, input logic [31:0] val,
                               input int pos, input bit fin);
        list_result_t r;
        r.status        = st;
        r.item_value    = val;
        r.item_position = 7'(pos);
        r.element_count = 7'(list_image.size());
        r.last          = fin;
        expected_results.push_back(r);
    endtask

    // applies one operation to the list image and queues what it must produce
    task automatic apply_list_op(input logic [2:0] fn, input logic [31:0] v,
                                 input logic [7:0] p);
        int pi;
        int n;
        logic [2:0] st;
        pi = int'(p);
        n  = list_image.size();
        st = ST_OK;
        case (fn)
            FN_INS_FRONT: begin
                if (n >= LIST_DEPTH) st = ST_FULL;
                else list_image.push_front(v);
            end
            FN_INS_BACK: begin
                if (n >= LIST_DEPTH) st = ST_FULL;
                else list_image.push_back(v);
            end
            FN_INS_POS: begin
                if (n >= LIST_DEPTH) st = ST_FULL;
                else if (pi < 1 || pi > n + 1) st = ST_BADPOS;
                else list_image.insert(pi - 1, v);
            end
            FN_DEL_FRONT: begin
                if (n == 0) st = ST_EMPTY;
                else void'(list_image.pop_front());
            end
            FN_DEL_BACK: begin
                if (n == 0) st = ST_EMPTY;
                else void'(list_image.pop_back());
            end
            FN_DEL_POS: begin
                if (n == 0) st = ST_EMPTY;
                else if (pi < 1 || pi > n) st = ST_BADPOS;
                else list_image.delete(pi - 1);
            end
            FN_SEARCH: begin
                if (n == 0) st = ST_EMPTY;
                else begin
                    for (int k = 0; k < n; k++) begin
                        if (list_image[k] == v) begin
                            push_result(ST_OK, list_image[k], k + 1, 1'b1);
                            return;
                        end
                    end
                    st = ST_NOTFOUND;
                end
            end
            default: begin
                if (n == 0) st = ST_EMPTY;
                else begin
                    for (int k = 0; k < n; k++)
                        push_result(ST_OK, list_image[k], k + 1, k == n - 1);
                    return;
                end
            end
        endcase
        push_result(st, '0, 0, 1'b1);
    endtask

    task automatic queue_op(input logic [2:0] fn, input logic [31:0] v,
                            input logic [7:0] p, input bit drain);
        list_op_t op;
        op.func     = fn;
        op.value    = v;
        op.position = p;
        op.drain    = drain;
        pending_ops.push_back(op);
    endtask

    // sampling and checking on the rising edge
    always @(posedge i_clk) begin
        list_result_t exp_r;
        bit in_xfer;
        bit out_xfer;
        in_xfer  = i_rst_n && i_in_valid && !o_in_stall;
        out_xfer = i_rst_n && o_out_valid && !i_out_stall;
        if (out_xfer) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result status=%0d value=%h",
                                          o_status, o_item_value));
            end else begin
                exp_r = expected_results.pop_front();
                if (o_status !== exp_r.status)
                    report_mismatch($sformatf("status %0d, want %0d",
                                              o_status, exp_r.status));
                if (o_item_value !== exp_r.item_value)
                    report_mismatch($sformatf("item_value %h, want %h",
                                              o_item_value, exp_r.item_value));
                if (o_item_position !== exp_r.item_position)
                    report_mismatch($sformatf("item_position %0d, want %0d",
                                              o_item_position, exp_r.item_position));
                if (o_element_count !== exp_r.element_count)
                    report_mismatch($sformatf("element_count %0d, want %0d",
                                              o_element_count, exp_r.element_count));
                if (o_last !== exp_r.last)
                    report_mismatch($sformatf("last %b, want %b", o_last, exp_r.last));
            end
        end
        if (in_xfer) begin
            apply_list_op(i_func, i_value, i_position);
            ops_accepted++;
        end
        if (in_xfer || out_xfer || !i_rst_n) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        list_op_t op;
        logic next_valid;
        next_valid = i_in_valid && (ops_accepted != ops_offered);
        if (i_rst_n && !next_valid && pending_ops.size() > 0) begin
            if (pending_ops[0].drain && expected_results.size() != 0) begin
                // hold off until the block has delivered everything
            end else if (!quiet && $urandom_range(0, 99) < 25) begin
            end else begin
                op = pending_ops.pop_front();
                i_func     <= op.func;
                i_value    <= op.value;
                i_position <= op.position;
                ops_offered++;
                next_valid = 1'b1;
            end
        end
        i_in_valid <= next_valid;
    end

    // output stall: random, plus one long hold so the block backs up
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!hold_done && ops_accepted >= 60) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !quiet && ($urandom_range(0, 99) < 25);
        end
    end

    initial begin
        int roll;
        int episode;
        logic [2:0]  fn;
        logic [31:0] v;
        logic [7:0]  p;

        // empty-list corner cases
        queue_op(FN_DUMP,      32'h0, 8'd0, 1'b0);
        queue_op(FN_SEARCH,    32'h0, 8'd0, 1'b0);
        queue_op(FN_DEL_FRONT, 32'h0, 8'd0, 1'b0);
        queue_op(FN_DEL_BACK,  32'h0, 8'd0, 1'b0);
        queue_op(FN_DEL_POS,   32'h0, 8'd1, 1'b0);
        queue_op(FN_INS_POS,   32'h1, 8'd2, 1'b0);
        queue_op(FN_INS_POS,   32'h1, 8'd0, 1'b0);
        // build a short list with extreme values, then search, dump and delete from it
        queue_op(FN_INS_POS,   32'h8000_0000, 8'd1, 1'b0);
        queue_op(FN_INS_FRONT, 32'h7fff_ffff, 8'd0, 1'b0);
        queue_op(FN_INS_BACK,  32'hffff_ffff, 8'd0, 1'b0);
        queue_op(FN_INS_POS,   32'h0,         8'd2, 1'b0);
        queue_op(FN_INS_POS,   32'h5a5a_5a5a, 8'd5, 1'b0);
        queue_op(FN_INS_POS,   32'h2,         8'd7, 1'b0);
        queue_op(FN_INS_POS,   32'h2,         8'd255, 1'b0);
        queue_op(FN_SEARCH,    32'hffff_ffff, 8'd0, 1'b0);
        queue_op(FN_SEARCH,    32'h0000_3039, 8'd0, 1'b0);
        queue_op(FN_DUMP,      32'h0, 8'd0, 1'b0);
        queue_op(FN_DEL_POS,   32'h0, 8'd0, 1'b0);
        queue_op(FN_DEL_POS,   32'h0, 8'd6, 1'b0);
        queue_op(FN_DEL_POS,   32'h0, 8'd5, 1'b0);
        queue_op(FN_DEL_POS,   32'h0, 8'd2, 1'b0);
        queue_op(FN_DEL_FRONT, 32'h0, 8'd0, 1'b0);
        queue_op(FN_DEL_BACK,  32'h0, 8'd0, 1'b0);
        queue_op(FN_DUMP,      32'h0, 8'd0, 1'b0);

        // random part in episodes: fill up, mixed, drain down
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            episode = (i / EPISODE_LEN) % 3;
            roll = $urandom_range(0, 99);
            if (episode == 0) begin
                if (roll < 80)      fn = FN_INS_FRONT + 3'($urandom_range(0, 2));
                else if (roll < 90) fn = FN_SEARCH;
                else if (roll < 95) fn = FN_DUMP;
                else                fn = FN_DEL_FRONT + 3'($urandom_range(0, 2));
            end else if (episode == 1) begin
                fn = 3'($urandom_range(0, 7));
            end else begin
                if (roll < 75)      fn = FN_DEL_FRONT + 3'($urandom_range(0, 2));
                else if (roll < 85) fn = FN_SEARCH;
                else if (roll < 92) fn = FN_DUMP;
                else                fn = FN_INS_FRONT + 3'($urandom_range(0, 2));
            end
            // pool values make search hits likely
            v = $urandom_range(0, 1) ? value_pool[$urandom_range(0, 7)] : $urandom();
            p = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, 18));
            queue_op(fn, v, p, (i == 0) || ($urandom_range(0, 49) == 0));
        end

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_ops.size() == 0 && ops_accepted == ops_offered);
        wait (expected_results.size() == 0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== positional_list_store_top.f =====
design/plst_pkg.sv
design/plst_mem.sv
design/positional_list_store_top.sv
tb/sv/tb.sv
